@@ hw/rtl/ps2d_pkg.sv @@
// ----------------------------------------------------------------------------
// ps2d_pkg
// Shared types, scancode constants and lookup tables for the PS/2 set-1
// scancode decoder with its character ring buffer.
// ----------------------------------------------------------------------------
package ps2d_pkg;

  // Prefix and modifier scancodes.
  localparam logic [7:0] SC_E0     = 8'hE0;
  localparam logic [7:0] SC_E1     = 8'hE1;
  localparam logic [6:0] SC_LSHIFT = 7'h2A;
  localparam logic [6:0] SC_RSHIFT = 7'h36;
  localparam logic [6:0] SC_CTRL   = 7'h1D;
  localparam logic [6:0] SC_ALT    = 7'h38;
  localparam logic [7:0] SC_CAPS   = 8'h3A;
  localparam logic [7:0] SC_SPACE  = 8'h39;

  // Function key scancodes and their special codes.
  localparam logic [7:0] SC_F1     = 8'h3B;
  localparam logic [7:0] SC_F10    = 8'h44;
  localparam logic [7:0] SC_F11    = 8'h57;
  localparam logic [7:0] SC_F12    = 8'h58;
  localparam logic [7:0] KEY_F1    = 8'h8A;
  localparam logic [7:0] KEY_F11   = 8'h94;
  localparam logic [7:0] KEY_F12   = 8'h95;

  // Codes below this index come from the ASCII tables.
  localparam logic [7:0] ASCII_KEYS = 8'h3A;

  // Depth of the queue between the decoder and the buffer engine.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Lookup result: hit says whether the code maps to anything.
  typedef struct packed {
    logic       hit;
    logic [7:0] code;
  } code_t;

  // One decoded request, as handed from the decoder to the buffer engine.
  typedef struct packed {
    logic       is_read;
    logic       push;
    logic [7:0] code;
    logic       toggle;
  } op_t;

  // Unshifted character for a make code below ASCII_KEYS; zero is unmapped.
  function automatic logic [7:0] plain_lookup(logic [5:0] idx);
    logic [7:0] c;
    case (idx)
      6'h01: c = 8'h1B;  6'h02: c = 8'h31;  6'h03: c = 8'h32;  6'h04: c = 8'h33;
      6'h05: c = 8'h34;  6'h06: c = 8'h35;  6'h07: c = 8'h36;  6'h08: c = 8'h37;
      6'h09: c = 8'h38;  6'h0A: c = 8'h39;  6'h0B: c = 8'h30;  6'h0C: c = 8'h2D;
      6'h0D: c = 8'h3D;  6'h0E: c = 8'h08;  6'h0F: c = 8'h09;
      6'h10: c = 8'h71;  6'h11: c = 8'h77;  6'h12: c = 8'h65;  6'h13: c = 8'h72;
      6'h14: c = 8'h74;  6'h15: c = 8'h79;  6'h16: c = 8'h75;  6'h17: c = 8'h69;
      6'h18: c = 8'h6F;  6'h19: c = 8'h70;  6'h1A: c = 8'h5B;  6'h1B: c = 8'h5D;
      6'h1C: c = 8'h0A;
      6'h1E: c = 8'h61;  6'h1F: c = 8'h73;  6'h20: c = 8'h64;  6'h21: c = 8'h66;
      6'h22: c = 8'h67;  6'h23: c = 8'h68;  6'h24: c = 8'h6A;  6'h25: c = 8'h6B;
      6'h26: c = 8'h6C;  6'h27: c = 8'h3B;  6'h28: c = 8'h27;  6'h29: c = 8'h60;
      6'h2B: c = 8'h5C;
      6'h2C: c = 8'h7A;  6'h2D: c = 8'h78;  6'h2E: c = 8'h63;  6'h2F: c = 8'h76;
      6'h30: c = 8'h62;  6'h31: c = 8'h6E;  6'h32: c = 8'h6D;  6'h33: c = 8'h2C;
      6'h34: c = 8'h2E;  6'h35: c = 8'h2F;  6'h39: c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Shifted form of an unshifted character.
  function automatic logic [7:0] shift_lookup(logic [7:0] lo);
    logic [7:0] c;
    case (lo) inside
      [8'h61:8'h7A]: c = lo - 8'h20;
      8'h31: c = 8'h21;  8'h32: c = 8'h40;  8'h33: c = 8'h23;  8'h34: c = 8'h24;
      8'h35: c = 8'h25;  8'h36: c = 8'h5E;  8'h37: c = 8'h26;  8'h38: c = 8'h2A;
      8'h39: c = 8'h28;  8'h30: c = 8'h29;  8'h2D: c = 8'h5F;  8'h3D: c = 8'h2B;
      8'h5B: c = 8'h7B;  8'h5D: c = 8'h7D;  8'h3B: c = 8'h3A;  8'h27: c = 8'h22;
      8'h60: c = 8'h7E;  8'h5C: c = 8'h7C;  8'h2C: c = 8'h3C;  8'h2E: c = 8'h3E;
      8'h2F: c = 8'h3F;
      default: c = lo;
    endcase
    return c;
  endfunction

  // Extended keys that follow an E0 prefix.
  function automatic code_t ext_lookup(logic [7:0] sc);
    code_t r;
    r.hit = 1'b1;
    case (sc)
      8'h1C, 8'h5A: r.code = 8'h0A;
      8'h48: r.code = 8'h80;
      8'h50: r.code = 8'h81;
      8'h4B: r.code = 8'h82;
      8'h4D: r.code = 8'h83;
      8'h47: r.code = 8'h84;
      8'h4F: r.code = 8'h85;
      8'h49: r.code = 8'h86;
      8'h51: r.code = 8'h87;
      8'h52: r.code = 8'h88;
      8'h53: r.code = 8'h89;
      default: begin
        r.hit  = 1'b0;
        r.code = 8'h00;
      end
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/ps2_set1_scancode_decoder_fifo.sv @@
// ----------------------------------------------------------------------------
// ps2_set1_scancode_decoder_fifo
// PS/2 set-1 scancode decoder feeding a character ring buffer.
// ----------------------------------------------------------------------------
// Usage: each request on the in_ channel is either a raw set-1 scancode byte
// (in_mode 0) or a read of one buffered character (in_mode 1). Every request
// gives exactly one result on the out_ channel, in order: char_valid and
// char_out for a read, has_char after the request, im_toggle for shift plus
// space, and dropped when a decoded character met a full buffer. The ring
// holds FIFO_DEPTH-1 characters.
// The block takes one request per cycle while in_ready is high. The decoder
// writes each accepted request into the two-entry operation queue, and the
// buffer engine, with its registered memory read, loads the result for the
// queue head into the output register.
// Reset clears the key state, the prefix flags, the queue and the buffer
// pointers; the character memory is not cleared and no sweep is needed.
// When the receiver stalls, the result waits in the output register, the
// queue fills, and in_ready falls once both queue entries are taken.
// ----------------------------------------------------------------------------
module ps2_set1_scancode_decoder_fifo
  import ps2d_pkg::*;
#(
  parameter int FIFO_DEPTH = 256
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_mode,
  input  logic [7:0] in_scan_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_char_valid,
  output logic [7:0] out_char_out,
  output logic       out_has_char,
  output logic       out_im_toggle,
  output logic       out_dropped
);

  logic q_push;
  op_t  q_in_op;
  logic q_pop;
  logic q_valid;
  op_t  q_head_op;

  // Decoder and key state.
  ps2d_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_mode      (in_mode),
    .in_scan_code (in_scan_code),
    .q_ready      (in_ready),
    .q_push       (q_push),
    .q_op         (q_in_op)
  );

  // Operation queue between decoder and buffer engine.
  ps2d_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (q_in_op),
    .ready   (in_ready),
    .pop     (q_pop),
    .valid   (q_valid),
    .head_op (q_head_op)
  );

  // Ring buffer and output register.
  ps2d_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .op_valid       (q_valid),
    .op             (q_head_op),
    .op_pop         (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char_valid (out_char_valid),
    .out_char_out   (out_char_out),
    .out_has_char   (out_has_char),
    .out_im_toggle  (out_im_toggle),
    .out_dropped    (out_dropped)
  );

endmodule

@@ hw/rtl/ps2d_front.sv @@
// ----------------------------------------------------------------------------
// ps2d_front
// Accepts scancode bytes and read requests, tracks modifier and prefix
// state, and turns each request into one operation for the buffer engine.
// ----------------------------------------------------------------------------
module ps2d_front
  import ps2d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_mode,
  input  logic [7:0] in_scan_code,
  input  logic       q_ready,
  output logic       q_push,
  output op_t        q_op
);

  logic shift_r, shift_nxt;
  logic ctrl_r, ctrl_nxt;
  logic alt_r, alt_nxt;
  logic caps_r, caps_nxt;
  logic e0_r, e0_nxt;
  logic e1_r, e1_nxt;
  logic [7:0] lo_char;
  logic       upper;
  code_t      ext;
  code_t      plain;

  assign q_push = in_valid && q_ready;

  // Plain make-code mapping: function keys, then the ASCII tables.
  always_comb begin
    lo_char = plain_lookup(in_scan_code[5:0]);
    if (lo_char inside {[8'h61:8'h7A]}) begin
      upper = shift_r ^ caps_r;
    end else begin
      upper = shift_r;
    end
    plain.hit  = 1'b0;
    plain.code = 8'h00;
    if (in_scan_code inside {[SC_F1:SC_F10]}) begin
      plain.hit  = 1'b1;
      plain.code = KEY_F1 + (in_scan_code - SC_F1);
    end else if (in_scan_code == SC_F11) begin
      plain.hit  = 1'b1;
      plain.code = KEY_F11;
    end else if (in_scan_code == SC_F12) begin
      plain.hit  = 1'b1;
      plain.code = KEY_F12;
    end else if (in_scan_code < ASCII_KEYS && lo_char != 8'h00) begin
      plain.hit  = 1'b1;
      plain.code = upper ? shift_lookup(lo_char) : lo_char;
    end
    ext = ext_lookup(in_scan_code);
  end

  // Decode in priority order and form the next state and the operation.
  always_comb begin
    shift_nxt = shift_r;
    ctrl_nxt  = ctrl_r;
    alt_nxt   = alt_r;
    caps_nxt  = caps_r;
    e0_nxt    = e0_r;
    e1_nxt    = e1_r;
    q_op.is_read = in_mode;
    q_op.push    = 1'b0;
    q_op.code    = 8'h00;
    q_op.toggle  = 1'b0;
    if (!in_mode) begin
      if (in_scan_code == SC_E0) begin
        e0_nxt = 1'b1;
      end else if (in_scan_code == SC_E1) begin
        e1_nxt = 1'b1;
      end else if (in_scan_code[7]) begin
        if (in_scan_code[6:0] == SC_LSHIFT || in_scan_code[6:0] == SC_RSHIFT) begin
          shift_nxt = 1'b0;
        end
        if (in_scan_code[6:0] == SC_CTRL) begin
          ctrl_nxt = 1'b0;
        end
        if (in_scan_code[6:0] == SC_ALT) begin
          alt_nxt = 1'b0;
        end
        e0_nxt = 1'b0;
        e1_nxt = 1'b0;
      end else if (in_scan_code[6:0] == SC_LSHIFT || in_scan_code[6:0] == SC_RSHIFT) begin
        shift_nxt = 1'b1;
      end else if (in_scan_code[6:0] == SC_CTRL) begin
        ctrl_nxt = 1'b1;
      end else if (in_scan_code[6:0] == SC_ALT) begin
        alt_nxt = 1'b1;
      end else if (in_scan_code == SC_CAPS) begin
        caps_nxt = !caps_r;
      end else if (in_scan_code == SC_SPACE && shift_r) begin
        q_op.toggle = 1'b1;
      end else if (e1_r) begin
        e1_nxt = 1'b0;
      end else if (e0_r) begin
        e0_nxt    = 1'b0;
        q_op.push = ext.hit;
        q_op.code = ext.code;
      end else begin
        q_op.push = plain.hit;
        q_op.code = plain.code;
      end
    end
  end

  // Key state advances only when the request is accepted.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= 1'b0;
      ctrl_r  <= 1'b0;
      alt_r   <= 1'b0;
      caps_r  <= 1'b0;
      e0_r    <= 1'b0;
      e1_r    <= 1'b0;
    end else if (q_push) begin
      shift_r <= shift_nxt;
      ctrl_r  <= ctrl_nxt;
      alt_r   <= alt_nxt;
      caps_r  <= caps_nxt;
      e0_r    <= e0_nxt;
      e1_r    <= e1_nxt;
    end
  end

endmodule

@@ hw/rtl/ps2d_queue.sv @@
// ----------------------------------------------------------------------------
// ps2d_queue
// Short register queue that carries decoded operations from the decoder
// to the buffer engine, so that either side can stall on its own.
// ----------------------------------------------------------------------------
module ps2d_queue
  import ps2d_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_op,
  output logic ready,
  input  logic pop,
  output logic valid,
  output op_t  head_op
);

  op_t                entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign ready   = cnt_r != Q_CNT_W'(Q_DEPTH);
  assign valid   = cnt_r != '0;
  assign head_op = entry_r[rd_ptr_r];

  // Pointer and count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

@@ hw/rtl/ps2d_back.sv @@
// ----------------------------------------------------------------------------
// ps2d_back
// Buffer engine: executes one decoded operation per cycle, while the output
// register is free or being emptied, against the character ring buffer and holds the result in an output register.
// ----------------------------------------------------------------------------
module ps2d_back
  import ps2d_pkg::*;
#(
  parameter int FIFO_DEPTH = 256
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       op_valid,
  input  op_t        op,
  output logic       op_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_char_valid,
  output logic [7:0] out_char_out,
  output logic       out_has_char,
  output logic       out_im_toggle,
  output logic       out_dropped
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  logic [7:0]       char_store_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [PTR_W-1:0] wp_inc;
  logic [PTR_W-1:0] rp_inc;
  logic             exec;
  logic             empty;
  logic             do_read;
  logic             do_write;
  logic             drop_nxt;
  logic             out_valid_r;
  logic             char_valid_r;
  logic             has_char_r;
  logic             im_toggle_r;
  logic             dropped_r;
  logic [7:0]       rd_data_r;

  // An operation runs when the output register is free or being emptied.
  assign exec   = op_valid && (!out_valid_r || out_ready);
  assign op_pop = exec;

  assign empty  = rp_r == wp_r;
  assign wp_inc = (wp_r == PTR_LAST) ? '0 : wp_r + 1'b1;
  assign rp_inc = (rp_r == PTR_LAST) ? '0 : rp_r + 1'b1;

  // Pointer updates; a write whose next slot is the read slot is dropped.
  always_comb begin
    do_read  = exec && op.is_read && !empty;
    drop_nxt = op.push && (wp_inc == rp_r);
    do_write = exec && !op.is_read && op.push && !drop_nxt;
    wp_nxt   = do_write ? wp_inc : wp_r;
    rp_nxt   = do_read ? rp_inc : rp_r;
  end

  // Control state and result flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      rp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      if (exec) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload is loaded with each executed operation.
  always_ff @(posedge clk) begin
    if (exec) begin
      char_valid_r <= do_read;
      has_char_r   <= rp_nxt != wp_nxt;
      im_toggle_r  <= !op.is_read && op.toggle;
      dropped_r    <= !op.is_read && drop_nxt;
    end
  end

  // Character memory: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (do_write) begin
      char_store_r[wp_r] <= op.code;
    end
    if (do_read) begin
      rd_data_r <= char_store_r[rp_r];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_char_valid = char_valid_r;
  assign out_char_out   = char_valid_r ? rd_data_r : 8'h00;
  assign out_has_char   = has_char_r;
  assign out_im_toggle  = im_toggle_r;
  assign out_dropped    = dropped_r;

  // A popped character and a dropped write never share one result.
  a_pop_drop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(char_valid_r && dropped_r))
    else $error("pop and drop flagged in the same result");

  // A stored character leaves the buffer non-empty.
  a_write_has_char: assert property (@(posedge clk) disable iff (!rst_n)
    do_write |=> has_char_r)
    else $error("buffer reported empty after a stored character");

  // A read on an empty buffer returns nothing and leaves it empty.
  a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
    exec && op.is_read && empty |=> !char_valid_r && !has_char_r)
    else $error("read on empty buffer produced a character");

endmodule

@@ bench/ps2_keystroke_checker.sv @@
// ----------------------------------------------------------------------------
// ps2_keystroke_checker
// Watches both channels of the scancode decoder. It keeps its own copy of the
// key state and the character ring, works out the result of every accepted
// request, and compares each accepted result with the oldest expectation.
// ----------------------------------------------------------------------------
module ps2_keystroke_checker
  import ps2d_pkg::*;
#(
  parameter int FIFO_DEPTH = 256
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic       in_mode,
  input  logic [7:0] in_scan_code,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       out_char_valid,
  input  logic [7:0] out_char_out,
  input  logic       out_has_char,
  input  logic       out_im_toggle,
  input  logic       out_dropped,
  output int         mismatches,
  output int         outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       char_valid;
    logic [7:0] char_out;
    logic       has_char;
    logic       im_toggle;
    logic       dropped;
  } key_result_t;

  // Characters for make codes 0x00 to 0x39, first entry at the top.
  localparam logic [8*58-1:0] LOWER_KEYS = {
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B,
    8'h6C, 8'h3B, 8'h27, 8'h60, 8'h00, 8'h5C,
    8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D, 8'h2C,
    8'h2E, 8'h2F, 8'h00, 8'h00, 8'h00, 8'h20
  };
  localparam logic [8*58-1:0] UPPER_KEYS = {
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B,
    8'h4C, 8'h3A, 8'h22, 8'h7E, 8'h00, 8'h7C,
    8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D, 8'h3C,
    8'h3E, 8'h3F, 8'h00, 8'h00, 8'h00, 8'h20
  };

  // Shadow copy of the key state and the character ring.
  logic        shift_down, ctrl_down, alt_down, caps_lock, ext_pending, pause_pending;
  int          head, tail;
  logic [7:0]  ring [FIFO_DEPTH];
  key_result_t expected_results [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // Work out the result of one request and advance the shadow state.
  task automatic decode_request(input logic mode, input logic [7:0] sc);
    key_result_t r;
    logic        emit, upper;
    logic [7:0]  code, lo, hi;
    int          idx;
    r    = '0;
    emit = 1'b0;
    code = 8'h00;
    idx  = sc;
    if (mode) begin
      if (head != tail) begin
        r.char_valid = 1'b1;
        r.char_out   = ring[head];
        head         = (head + 1) % FIFO_DEPTH;
      end
    end else if (sc == SC_E0) begin
      ext_pending = 1'b1;
    end else if (sc == SC_E1) begin
      pause_pending = 1'b1;
    end else if (sc[7]) begin
      // Break code: release the modifier and forget any prefix.
      if (sc[6:0] == SC_LSHIFT || sc[6:0] == SC_RSHIFT) shift_down = 1'b0;
      if (sc[6:0] == SC_CTRL) ctrl_down = 1'b0;
      if (sc[6:0] == SC_ALT) alt_down = 1'b0;
      ext_pending   = 1'b0;
      pause_pending = 1'b0;
    end else if (sc[6:0] == SC_LSHIFT || sc[6:0] == SC_RSHIFT) begin
      shift_down = 1'b1;
    end else if (sc[6:0] == SC_CTRL) begin
      ctrl_down = 1'b1;
    end else if (sc[6:0] == SC_ALT) begin
      alt_down = 1'b1;
    end else if (sc == SC_CAPS) begin
      caps_lock = !caps_lock;
    end else if (sc == SC_SPACE && shift_down) begin
      r.im_toggle = 1'b1;
    end else if (pause_pending) begin
      pause_pending = 1'b0;
    end else if (ext_pending) begin
      ext_pending = 1'b0;
      emit        = 1'b1;
      case (sc)
        8'h1C, 8'h5A: code = 8'h0A;
        8'h48: code = 8'h80;
        8'h50: code = 8'h81;
        8'h4B: code = 8'h82;
        8'h4D: code = 8'h83;
        8'h47: code = 8'h84;
        8'h4F: code = 8'h85;
        8'h49: code = 8'h86;
        8'h51: code = 8'h87;
        8'h52: code = 8'h88;
        8'h53: code = 8'h89;
        default: emit = 1'b0;
      endcase
    end else if (sc >= SC_F1 && sc <= SC_F10) begin
      emit = 1'b1;
      code = KEY_F1 + (sc - SC_F1);
    end else if (sc == SC_F11) begin
      emit = 1'b1;
      code = KEY_F11;
    end else if (sc == SC_F12) begin
      emit = 1'b1;
      code = KEY_F12;
    end else if (sc < ASCII_KEYS) begin
      lo = LOWER_KEYS[8*(57-idx) +: 8];
      hi = UPPER_KEYS[8*(57-idx) +: 8];
      if (lo != 8'h00) begin
        // Letters follow shift xor caps lock, everything else only shift.
        if (lo >= 8'h61 && lo <= 8'h7A) upper = shift_down ^ caps_lock;
        else upper = shift_down;
        emit = 1'b1;
        code = upper ? hi : lo;
      end
    end

    // The ring keeps one slot free; a character that meets a full ring is lost.
    if (emit) begin
      if ((tail + 1) % FIFO_DEPTH == head) begin
        r.dropped = 1'b1;
      end else begin
        ring[tail] = code;
        tail       = (tail + 1) % FIFO_DEPTH;
      end
    end
    r.has_char = (head != tail);
    expected_results.push_back(r);
  endtask

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Predict on every accepted request, compare on every accepted result.
  always @(posedge clk) begin : watch_channels
    key_result_t want;
    if (!rst_n) begin
      shift_down    = 1'b0;
      ctrl_down     = 1'b0;
      alt_down      = 1'b0;
      caps_lock     = 1'b0;
      ext_pending   = 1'b0;
      pause_pending = 1'b0;
      head          = 0;
      tail          = 0;
      expected_results.delete();
    end else begin
      if (in_valid && in_ready) decode_request(in_mode, in_scan_code);
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t ns: result with no request waiting, char_out 0x%0h",
                   $time, out_char_out);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("char_valid", want.char_valid, out_char_valid);
          check_field("char_out", want.char_out, out_char_out);
          check_field("has_char", want.has_char, out_has_char);
          check_field("im_toggle", want.im_toggle, out_im_toggle);
          check_field("dropped", want.dropped, out_dropped);
        end
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

@@ bench/ps2_set1_scancode_decoder_fifo_test.sv @@
// ----------------------------------------------------------------------------
// ps2_set1_scancode_decoder_fifo_test
// Drives scancode and read requests into the decoder with bursty timing and a
// stalling receiver: a directed pass over the key classes and prefixes, a
// flood that overruns the character ring behind a long receiver hold-off,
// then random key sequences mixed with noise. A separate checker predicts
// and compares every result.
// ----------------------------------------------------------------------------
module ps2_set1_scancode_decoder_fifo_test
  import ps2d_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH     = 256;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF_LEN   = 400;
  localparam int RANDOM_ITEMS   = 50;

  logic       clk;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_mode      = 1'b0;
  logic [7:0] in_scan_code = 8'h00;
  logic       out_ready    = 1'b0;
  logic       in_ready, out_valid;
  logic       out_char_valid, out_has_char, out_im_toggle, out_dropped;
  logic [7:0] out_char_out;
  int         mismatches, outstanding;
  int         burst_left   = 0;
  int         idle_cycles  = 0;
  logic       hold_off_due = 1'b0;

  ps2_set1_scancode_decoder_fifo #(.FIFO_DEPTH(RING_DEPTH)) dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_mode, .in_scan_code,
    .out_valid, .out_ready, .out_char_valid, .out_char_out,
    .out_has_char, .out_im_toggle, .out_dropped
  );

  ps2_keystroke_checker #(.FIFO_DEPTH(RING_DEPTH)) scoreboard (
    .clk, .rst_n, .in_valid, .in_ready, .in_mode, .in_scan_code,
    .out_valid, .out_ready, .out_char_valid, .out_char_out,
    .out_has_char, .out_im_toggle, .out_dropped,
    .mismatches, .outstanding
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Offer one request; bursts of random length are separated by random gaps.
  task automatic send_request(input logic mode, input logic [7:0] code);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_scan_code <= code;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic press(input logic [7:0] code);
    send_request(1'b0, code);
  endtask

  task automatic fetch_char();
    send_request(1'b1, 8'($urandom_range(0, 255)));
  endtask

  // One random step: mostly well-formed key sequences, some reads, some noise.
  task automatic random_step();
    int         pick;
    logic [6:0] shift_key;
    pick      = $urandom_range(0, 99);
    shift_key = $urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT;
    if (pick < 30) begin
      fetch_char();
    end else if (pick < 52) begin
      press(8'($urandom_range(1, 8'h39)));
    end else if (pick < 60) begin
      press({1'b0, shift_key});
      press(8'($urandom_range(1, 8'h39)));
      press({1'b1, shift_key});
    end else if (pick < 68) begin
      // Extended key, sometimes followed by an extended break code.
      press(SC_E0);
      case ($urandom_range(0, 4))
        0: press(8'h1C);
        1: press(8'h5A);
        2: press(8'($urandom_range(0, 8'h7F)));
        default: press(8'($urandom_range(8'h47, 8'h53)));
      endcase
      if ($urandom_range(0, 1)) begin
        press(SC_E0);
        press(8'($urandom_range(8'hC7, 8'hD3)));
      end
    end else if (pick < 72) begin
      // Pause key sequence.
      press(SC_E1);
      press({1'b0, SC_CTRL});
      press(8'h45);
      press(SC_E1);
      press({1'b1, SC_CTRL});
      press(8'hC5);
    end else if (pick < 76) begin
      press(SC_CAPS);
    end else if (pick < 81) begin
      case ($urandom_range(0, 5))
        0: press(SC_F11);
        1: press(SC_F12);
        default: press(8'($urandom_range(SC_F1, SC_F10)));
      endcase
    end else if (pick < 86) begin
      press({$urandom_range(0, 1) == 1, $urandom_range(0, 1) ? SC_CTRL : SC_ALT});
    end else if (pick < 90) begin
      press({1'b0, shift_key});
      press(SC_SPACE);
      press({1'b1, shift_key});
    end else begin
      send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    end
  endtask

  // Receiver: stretches of differing stall patterns, and one long hold-off.
  initial begin : receiver
    int style, len, n;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_due) begin
        hold_off_due = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_LEN) @(posedge clk);
      end else begin
        style = $urandom_range(0, 3);
        len   = $urandom_range(8, 60);
        for (n = 0; n < len; n++) begin
          case (style)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            2: out_ready <= (n % 3 == 0);
            default: out_ready <= 1'($urandom_range(0, 1));
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Watchdog: too long without any accepted request or result ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("ps2_set1_scancode_decoder_fifo_test: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int n;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reads on empty, case rules, toggle, prefixes, function keys.
    send_request(1'b1, 8'hFF);
    press(8'h00);
    press(8'h1E);
    send_request(1'b1, 8'h00);
    press(SC_CAPS);
    press(8'h1E);
    press({1'b0, SC_LSHIFT});
    press(8'h1E);
    press(8'h02);
    press(SC_SPACE);
    press({1'b1, SC_LSHIFT});
    press(SC_CAPS);
    press(SC_SPACE);
    press(SC_E0);
    press(8'h48);
    press(SC_E0);
    press(8'h10);
    press(SC_E1);
    press({1'b0, SC_CTRL});
    press(8'h45);
    press({1'b1, SC_CTRL});
    press(SC_F1);
    press(SC_F10);
    press(SC_F11);
    press(SC_F12);
    press({1'b0, SC_ALT});
    press({1'b1, SC_ALT});
    press({1'b0, SC_RSHIFT});
    press(8'h35);
    press({1'b1, SC_RSHIFT});
    press(8'h7F);
    press(8'h80);
    repeat (16) fetch_char();

    // Flood the ring past full while the receiver holds off, then read a few back.
    hold_off_due = 1'b1;
    press({1'b1, SC_LSHIFT});
    for (n = 0; n < RING_DEPTH + 6; n++) begin
      press($urandom_range(0, 1) ? 8'($urandom_range(8'h10, 8'h19))
                                 : 8'($urandom_range(8'h1E, 8'h26)));
    end
    repeat (20) fetch_char();

    // Random sequences.
    for (n = 0; n < RANDOM_ITEMS; n++) random_step();

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("ps2_set1_scancode_decoder_fifo_test: done, clean");
    end else begin
      $display("ps2_set1_scancode_decoder_fifo_test: done, errors");
    end
    $finish;
  end

endmodule
